// ===== design/ecc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_pkg
// Shared types and codes of the elevator call controller.
// ----------------------------------------------------------------------------
package ecc_pkg;

   localparam int CARS_DEF   = 1;
   localparam int FLOORS_DEF = 10;
   localparam int CAR_W      = 3;
   localparam int FLOOR_W    = 6;

   // event codes
   localparam logic [1:0] OP_POSITION  = 2'd0;
   localparam logic [1:0] OP_HALL_CALL = 2'd1;
   localparam logic [1:0] OP_CAR_CALL  = 2'd2;
   localparam logic [1:0] OP_DWELL     = 2'd3;

   // direction / command codes
   localparam logic [1:0] DIR_UP   = 2'd0;
   localparam logic [1:0] DIR_DOWN = 2'd1;
   localparam logic [1:0] DIR_STOP = 2'd2;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [CAR_W-1:0]   car;
      logic [FLOOR_W-1:0] floor;
      logic [1:0]         direction;
   } req_type;

   typedef struct packed {
      logic [1:0]       command;
      logic [CAR_W-1:0] target_car;
   } rsp_type;

   // hall-call table write port: bit 0 up, bit 1 down
   typedef struct packed {
      logic               en;
      logic [FLOOR_W-1:0] addr;
      logic [1:0]         bits;
   } hall_wr_type;

endpackage

// ===== design/ecc_hall_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_hall_mem
// Per-floor up/down hall-call table with registered read and per-entry
// valid bits so that entries read as zero until first written after reset.
// ----------------------------------------------------------------------------
module ecc_hall_mem #(
   parameter int FLOORS = ecc_pkg::FLOORS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [ecc_pkg::FLOOR_W-1:0] rd_addr,
   output logic [1:0]                  rd_bits,
   input  ecc_pkg::hall_wr_type        hall_wr
);
   import ecc_pkg::*;

   localparam int IDX_W = $clog2(FLOORS);

   logic [1:0]        mem [FLOORS];
   logic [FLOORS-1:0] valid_ff;
   logic [1:0]        rd_q_ff;
   logic              rd_vld_ff;

   always_ff @(posedge clock) begin
      if (hall_wr.en) begin
         mem[hall_wr.addr[IDX_W-1:0]] <= hall_wr.bits;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (hall_wr.en) begin
            valid_ff[hall_wr.addr[IDX_W-1:0]] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= valid_ff[rd_addr[IDX_W-1:0]];
         end
      end
   end

   assign rd_bits = rd_q_ff & {2{rd_vld_ff}};

endmodule

// ===== design/ecc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_core
// Car state registers, stop / dispatch / resume decision and result register.
// ----------------------------------------------------------------------------
module ecc_core #(
   parameter int CARS   = ecc_pkg::CARS_DEF,
   parameter int FLOORS = ecc_pkg::FLOORS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_vld,
   input  ecc_pkg::req_type     item,
   input  logic [1:0]           hall_rd,
   output ecc_pkg::hall_wr_type hall_wr,
   output logic                 rsp_strobe,
   output ecc_pkg::rsp_type     rsp
);
   import ecc_pkg::*;

   localparam int CAR_IDX_W = (CARS > 1) ? $clog2(CARS) : 1;
   localparam int FL_IDX_W  = $clog2(FLOORS);
   localparam logic [CAR_W:0]   CAR_LIM   = (CAR_W+1)'(CARS);
   localparam logic [FLOOR_W:0] FLOOR_LIM = (FLOOR_W+1)'(FLOORS);

   logic [FLOORS-1:0]  car_call_ff [CARS];
   logic [FLOORS-1:0]  car_call_in [CARS];
   logic [FLOOR_W-1:0] position_ff [CARS];
   logic [FLOOR_W-1:0] position_in [CARS];
   logic [1:0]         heading_ff  [CARS];
   logic [1:0]         heading_in  [CARS];
   logic [CARS-1:0]    resume_ff;
   logic [CARS-1:0]    resume_in;

   // last hall-table write, forwarded over the registered table read
   logic               fwd_vld_ff;
   logic [FLOOR_W-1:0] fwd_floor_ff;
   logic [1:0]         fwd_bits_ff;

   logic    rsp_strobe_ff, rsp_strobe_in;
   rsp_type rsp_ff, rsp_in;

   logic                 car_ok, floor_ok;
   logic [CAR_IDX_W-1:0] ci;
   logic [FL_IDX_W-1:0]  fi;
   logic [1:0]           dir_eff;
   logic                 same_sel;
   logic [1:0]           hall_cur;
   logic [FLOORS-1:0]    row;
   logic [FLOORS-1:0]    fmask;
   logic                 row_zero, call_hit, same_bit, other_bit, stop;
   logic                 idle_found;
   logic [CAR_W-1:0]     idle_idx;
   logic [FLOOR_W-1:0]   idle_pos;

   always_comb begin
      car_ok    = {1'b0, item.car} < CAR_LIM;
      floor_ok  = {1'b0, item.floor} < FLOOR_LIM;
      ci        = item.car[CAR_IDX_W-1:0];
      fi        = item.floor[FL_IDX_W-1:0];
      dir_eff   = (item.direction == DIR_UP || item.direction == DIR_DOWN) ?
                  item.direction : DIR_STOP;
      same_sel  = (dir_eff != DIR_UP);
      hall_cur  = (fwd_vld_ff && fwd_floor_ff == item.floor) ? fwd_bits_ff : hall_rd;
      row       = car_call_ff[ci];
      fmask     = FLOORS'(1) << fi;
      row_zero  = (row == '0);
      call_hit  = |(row & fmask);
      same_bit  = hall_cur[same_sel];
      other_bit = hall_cur[~same_sel];
      stop      = call_hit || same_bit || (other_bit && row_zero);

      // lowest-index idle car
      idle_found = 1'b0;
      idle_idx   = '0;
      idle_pos   = '0;
      for (int k = 0; k < CARS; k++) begin
         if (!idle_found && heading_ff[k] == DIR_STOP) begin
            idle_found = 1'b1;
            idle_idx   = CAR_W'(k);
            idle_pos   = position_ff[k];
         end
      end

      car_call_in   = car_call_ff;
      position_in   = position_ff;
      heading_in    = heading_ff;
      resume_in     = resume_ff;
      hall_wr       = '0;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      if (item_vld) begin
         case (item.opcode)
            OP_POSITION: begin
               if (car_ok && floor_ok) begin
                  position_in[ci] = item.floor;
                  heading_in[ci]  = dir_eff;
                  if (stop) begin
                     car_call_in[ci]   = row & ~fmask;
                     hall_wr.en        = 1'b1;
                     hall_wr.addr      = item.floor;
                     hall_wr.bits      = hall_cur & ~(2'b01 << same_sel);
                     resume_in[ci]     = same_sel;
                     rsp_strobe_in     = 1'b1;
                     rsp_in.command    = DIR_STOP;
                     rsp_in.target_car = item.car;
                  end
               end
            end
            OP_HALL_CALL: begin
               if (floor_ok) begin
                  hall_wr.en   = 1'b1;
                  hall_wr.addr = item.floor;
                  hall_wr.bits = hall_cur | (2'b01 << same_sel);
                  if (idle_found) begin
                     rsp_strobe_in     = 1'b1;
                     rsp_in.command    = (idle_pos < item.floor) ? DIR_UP : DIR_DOWN;
                     rsp_in.target_car = idle_idx;
                  end
               end
            end
            OP_CAR_CALL: begin
               if (car_ok && floor_ok) begin
                  car_call_in[ci] = row | fmask;
               end
            end
            OP_DWELL: begin
               if (car_ok && !row_zero) begin
                  rsp_strobe_in     = 1'b1;
                  rsp_in.command    = resume_ff[ci] ? DIR_DOWN : DIR_UP;
                  rsp_in.target_car = item.car;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CARS; k++) begin
            car_call_ff[k] <= '0;
            position_ff[k] <= '0;
            heading_ff[k]  <= DIR_STOP;
         end
         resume_ff     <= '0;
         fwd_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         car_call_ff   <= car_call_in;
         position_ff   <= position_in;
         heading_ff    <= heading_in;
         resume_ff     <= resume_in;
         fwd_vld_ff    <= hall_wr.en;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_floor_ff <= hall_wr.addr;
      fwd_bits_ff  <= hall_wr.bits;
      rsp_ff       <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

`ifndef NO_ASSERTIONS
   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(item_vld))
      else $error("result without an item in the decision stage");

   a_report_stops: assert property (@(posedge clock) disable iff (reset)
      item_vld && item.opcode == OP_POSITION |=> !rsp_strobe_ff || rsp_ff.command == DIR_STOP)
      else $error("position report produced a non-stop command");

   a_dispatch_moves: assert property (@(posedge clock) disable iff (reset)
      item_vld && item.opcode == OP_HALL_CALL |=> !rsp_strobe_ff || rsp_ff.command != DIR_STOP)
      else $error("hall call dispatch produced a stop command");

   a_car_call_silent: assert property (@(posedge clock) disable iff (reset)
      item_vld && item.opcode == OP_CAR_CALL |=> !rsp_strobe_ff)
      else $error("car call produced a result");

   a_target_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> ({1'b0, rsp_ff.target_car} < CAR_LIM))
      else $error("command sent to a car that does not exist");
`endif

endmodule

// ===== design/elevator_call_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_call_controller_top
// Call bookkeeping and stop / dispatch / resume decisions for a car bank.
// ----------------------------------------------------------------------------
// One event is taken on every clock (busy is high only while reset is held).
// The event is registered and its hall-call table entry read on the
// transferring edge; the decision and all state updates happen in the next
// cycle. A result, when there is one, is registered at the end of that
// cycle and shows on rsp_data with rsp_strobe high for one cycle.
// rsp_strobe cannot be held off: the receiver must take each result in
// the cycle it appears.
// ----------------------------------------------------------------------------
module elevator_call_controller_top #(
   parameter int CARS   = ecc_pkg::CARS_DEF,
   parameter int FLOORS = ecc_pkg::FLOORS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ecc_pkg::req_type req_data,
   output logic             rsp_strobe,
   output ecc_pkg::rsp_type rsp_data
);
   import ecc_pkg::*;

   localparam logic [FLOOR_W:0] FLOOR_LIM = (FLOOR_W+1)'(FLOORS);

   logic        accept;
   logic        rd_en;
   req_type     item_ff;
   logic        item_vld_ff;
   logic [1:0]  hall_rd;
   hall_wr_type hall_wr;

   assign busy   = reset;
   assign accept = start && !busy;
   assign rd_en  = accept && ({1'b0, req_data.floor} < FLOOR_LIM);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else begin
         item_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
   end

   ecc_hall_mem #(
      .FLOORS (FLOORS)
   ) u_hall_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (req_data.floor),
      .rd_bits (hall_rd),
      .hall_wr (hall_wr)
   );

   ecc_core #(
      .CARS   (CARS),
      .FLOORS (FLOORS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_vld   (item_vld_ff),
      .item       (item_ff),
      .hall_rd    (hall_rd),
      .hall_wr    (hall_wr),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_data)
   );

endmodule
